### sv/coin_register_change_maker_macros.svh
// ----------------------------------------------------------------------------
// coin register change maker assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef COIN_REGISTER_CHANGE_MAKER_MACROS_SVH
`define COIN_REGISTER_CHANGE_MAKER_MACROS_SVH

// same-cycle implication
`define CRCM_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("crcm assertion failed");

// next-cycle implication
`define CRCM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("crcm assertion failed");

`endif

### sv/crcm_pkg.sv
// ----------------------------------------------------------------------------
// crcm_pkg
// types, constants and denomination tables for the coin register change maker
// ----------------------------------------------------------------------------
package crcm_pkg;

    localparam int NUM_COIN_KINDS = 8;
    localparam int DENOM_WIDTH    = $clog2(NUM_COIN_KINDS);
    localparam int COUNT_WIDTH    = 16;
    localparam int QTY_WIDTH      = 16;
    localparam int AMOUNT_WIDTH   = 16;
    localparam int KIND_WIDTH     = 2;
    localparam int VALUE_WIDTH    = 10;
    localparam int RECIP_SHIFT    = 24;
    localparam int PROD_WIDTH     = AMOUNT_WIDTH + RECIP_SHIFT;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [KIND_WIDTH-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_CHANGE = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_READ   = 2'd2;

    localparam logic [DENOM_WIDTH-1:0] DENOM_LOWEST  = '0;
    localparam logic [DENOM_WIDTH-1:0] DENOM_HIGHEST = DENOM_WIDTH'(NUM_COIN_KINDS - 1);

    typedef struct packed {
        logic [KIND_WIDTH-1:0]   kind;
        logic [DENOM_WIDTH-1:0]  denom_select;
        logic [QTY_WIDTH-1:0]    quantity;
        logic [AMOUNT_WIDTH-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [DENOM_WIDTH-1:0] out_denom;
        logic [COUNT_WIDTH-1:0] coin_count;
        logic                   success;
        logic                   last;
    } rsp_t;

    // coin value in cents
    function automatic logic [VALUE_WIDTH-1:0] coin_value(input logic [DENOM_WIDTH-1:0] idx);
        logic [VALUE_WIDTH-1:0] v;
        begin
            unique case (idx)
                3'd0:    v = 10'd5;
                3'd1:    v = 10'd10;
                3'd2:    v = 10'd20;
                3'd3:    v = 10'd50;
                3'd4:    v = 10'd100;
                3'd5:    v = 10'd200;
                3'd6:    v = 10'd500;
                3'd7:    v = 10'd1000;
                default: v = 10'd5;
            endcase
            return v;
        end
    endfunction

    // floor(2^RECIP_SHIFT / value), quotient estimate is exact or one low
    function automatic logic [RECIP_SHIFT-1:0] coin_recip(input logic [DENOM_WIDTH-1:0] idx);
        logic [RECIP_SHIFT-1:0] r;
        begin
            unique case (idx)
                3'd0:    r = 24'd3355443;
                3'd1:    r = 24'd1677721;
                3'd2:    r = 24'd838860;
                3'd3:    r = 24'd335544;
                3'd4:    r = 24'd167772;
                3'd5:    r = 24'd83886;
                3'd6:    r = 24'd33554;
                3'd7:    r = 24'd16777;
                default: r = 24'd3355443;
            endcase
            return r;
        end
    endfunction

endpackage

### sv/coin_register_change_maker.sv
// insert and read: result loaded when the output is free, next item accepted after that
// change request: each denomination steps through S_RECIP, S_CHECK, S_FIX, S_TAKE, S_SUB
//   on one shared multiplier, then eight results at one per cycle while rsp_ready is high
// input is not accepted until the last result of an item is loaded into the output register
// reset (rst_n, asynchronous) clears all coin counts to zero and empties the output register
// ----------------------------------------------------------------------------
// coin_register_change_maker
// eight-denomination coin store with saturating insert, count read and
// greedy change payout that leaves the store untouched when change fails
// ----------------------------------------------------------------------------
`include "coin_register_change_maker_macros.svh"

module coin_register_change_maker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  crcm_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output crcm_pkg::rsp_t  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_RECIP,
        S_CHECK,
        S_FIX,
        S_TAKE,
        S_SUB,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [crcm_pkg::COUNT_WIDTH-1:0]  counts_reg [crcm_pkg::NUM_COIN_KINDS];
    logic [crcm_pkg::COUNT_WIDTH-1:0]  counts_next [crcm_pkg::NUM_COIN_KINDS];
    logic [crcm_pkg::COUNT_WIDTH-1:0]  paid_reg [crcm_pkg::NUM_COIN_KINDS];
    logic [crcm_pkg::COUNT_WIDTH-1:0]  paid_next [crcm_pkg::NUM_COIN_KINDS];
    logic [crcm_pkg::DENOM_WIDTH-1:0]  idx_reg, idx_next;
    logic [crcm_pkg::KIND_WIDTH-1:0]   kind_reg, kind_next;
    logic [crcm_pkg::QTY_WIDTH-1:0]    qty_reg, qty_next;
    logic [crcm_pkg::AMOUNT_WIDTH-1:0] rest_reg, rest_next;
    logic [crcm_pkg::AMOUNT_WIDTH-1:0] q_reg, q_next;
    logic [crcm_pkg::PROD_WIDTH-1:0]   prod_reg, prod_next;
    logic                              ok_reg, ok_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    crcm_pkg::rsp_t                    rsp_reg, rsp_next;

    // shared multiplier
    logic [crcm_pkg::AMOUNT_WIDTH-1:0] mul_a;
    logic [crcm_pkg::RECIP_SHIFT-1:0]  mul_b;
    logic [crcm_pkg::PROD_WIDTH-1:0]   prod;

    logic [crcm_pkg::VALUE_WIDTH-1:0]  value;
    logic [crcm_pkg::COUNT_WIDTH-1:0]  cur_count;
    logic [crcm_pkg::AMOUNT_WIDTH-1:0] q_est;
    logic [crcm_pkg::AMOUNT_WIDTH-1:0] rem;
    logic [crcm_pkg::COUNT_WIDTH-1:0]  take;
    logic [crcm_pkg::COUNT_WIDTH:0]    sum;
    logic                              sat;
    logic                              out_free;
    logic                              req_fire;
    logic                              req_known;
    logic                              rsp_fail_mid;

    assign value     = crcm_pkg::coin_value(idx_reg);
    assign cur_count = counts_reg[idx_reg];
    assign q_est     = prod_reg[crcm_pkg::RECIP_SHIFT +: crcm_pkg::AMOUNT_WIDTH];
    assign rem       = rest_reg - prod_reg[crcm_pkg::AMOUNT_WIDTH-1:0];
    assign take      = (q_reg < cur_count) ? q_reg : cur_count;
    assign sum       = {1'b0, cur_count} + {1'b0, qty_reg};
    assign sat       = sum[crcm_pkg::COUNT_WIDTH];
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_known    = req_fire && (req.kind == crcm_pkg::KIND_INSERT ||
                                       req.kind == crcm_pkg::KIND_CHANGE ||
                                       req.kind == crcm_pkg::KIND_READ);
    assign rsp_fail_mid = rsp_valid && !rsp.last && !rsp.success;

    always_comb
    begin
        unique case (state_reg)
            S_RECIP:
            begin
                mul_a = rest_reg;
                mul_b = crcm_pkg::coin_recip(idx_reg);
            end
            S_CHECK:
            begin
                mul_a = q_est;
                mul_b = crcm_pkg::RECIP_SHIFT'(value);
            end
            default:
            begin
                mul_a = take;
                mul_b = crcm_pkg::RECIP_SHIFT'(value);
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        counts_next    = counts_reg;
        paid_next      = paid_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        qty_next       = qty_reg;
        rest_next      = rest_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        ok_next        = ok_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next = req.kind;
                    qty_next  = req.quantity;
                    rest_next = req.amount;
                    unique case (req.kind) inside
                        crcm_pkg::KIND_INSERT, crcm_pkg::KIND_READ:
                        begin
                            idx_next   = req.denom_select;
                            state_next = S_SINGLE;
                        end
                        crcm_pkg::KIND_CHANGE:
                        begin
                            idx_next   = crcm_pkg::DENOM_HIGHEST;
                            state_next = S_RECIP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.out_denom = idx_reg;
                    rsp_next.last      = 1'b1;
                    if (kind_reg == crcm_pkg::KIND_INSERT)
                    begin
                        counts_next[idx_reg] = sat ? crcm_pkg::COUNT_MAX
                                                   : sum[crcm_pkg::COUNT_WIDTH-1:0];
                        rsp_next.coin_count  = counts_next[idx_reg];
                        rsp_next.success     = !sat;
                    end
                    else
                    begin
                        rsp_next.coin_count = cur_count;
                        rsp_next.success    = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_RECIP:
            begin
                prod_next  = prod;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                q_next     = q_est;
                prod_next  = prod;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (rem >= crcm_pkg::AMOUNT_WIDTH'(value))
                begin
                    q_next = q_reg + 1'b1;
                end
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                paid_next[idx_reg] = take;
                prod_next          = prod;
                state_next         = S_SUB;
            end
            S_SUB:
            begin
                rest_next = rem;
                if (idx_reg == crcm_pkg::DENOM_LOWEST)
                begin
                    ok_next    = (rem == '0);
                    idx_next   = crcm_pkg::DENOM_HIGHEST;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_RECIP;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.out_denom  = idx_reg;
                    rsp_next.coin_count = ok_reg ? paid_reg[idx_reg] : '0;
                    rsp_next.success    = ok_reg;
                    rsp_next.last       = (idx_reg == crcm_pkg::DENOM_LOWEST);
                    if (ok_reg)
                    begin
                        counts_next[idx_reg] = cur_count - paid_reg[idx_reg];
                    end
                    if (idx_reg == crcm_pkg::DENOM_LOWEST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < crcm_pkg::NUM_COIN_KINDS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            counts_reg    <= counts_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        paid_reg <= paid_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        qty_reg  <= qty_next;
        rest_reg <= rest_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        ok_reg   <= ok_next;
        rsp_reg  <= rsp_next;
    end

    `CRCM_ASSERT_NEXT(a_busy_after_item, req_known, !req_ready)
    `CRCM_ASSERT_IMPL(a_failed_change_pays_nothing, rsp_fail_mid, rsp.coin_count == '0)
    `CRCM_ASSERT_IMPL(a_no_accept_mid_payout, rsp_valid && !rsp.last, !req_ready)

endmodule
